// ----- hdl/vtpc_pkg.sv -----
// ----------------------------------------------------------------------------
// vtpc_pkg
// Shared types and codes of the virtual texture page cache.
// ----------------------------------------------------------------------------
package vtpc_pkg;

  localparam int STALE_DEPTH = 256;

  localparam logic [2:0] CFG_VIRTUAL_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_VIRTUAL_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_PAGE_SIZE_LOG2 = 3'd2;
  localparam logic [2:0] CFG_MIP_LEVELS     = 3'd3;
  localparam logic [2:0] CFG_CACHE_PAGES_X  = 3'd4;
  localparam logic [2:0] CFG_CACHE_PAGES_Y  = 3'd5;
  localparam logic [2:0] CFG_STALE_AGE      = 3'd6;

  localparam logic [2:0] KIND_QUEUED       = 3'd0;
  localparam logic [2:0] KIND_ALREADY      = 3'd1;
  localparam logic [2:0] KIND_OUT_OF_RANGE = 3'd2;
  localparam logic [2:0] KIND_QUEUE_FULL   = 3'd3;
  localparam logic [2:0] KIND_LOADED       = 3'd4;
  localparam logic [2:0] KIND_SKIPPED      = 3'd5;
  localparam logic [2:0] KIND_NO_SLOT      = 3'd6;
  localparam logic [2:0] KIND_TICK_DONE    = 3'd7;

  typedef struct packed {
    logic        command;
    logic [13:0] page_x;
    logic [13:0] page_y;
    logic [3:0]  mip_level;
    logic [31:0] frame;
  } req_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [10:0] page_index;
    logic [7:0]  slot;
    logic        evicted;
    logic [10:0] evicted_page;
    logic [8:0]  stale_added;
    logic        last;
  } rsp_t;

endpackage

// ----- hdl/vtpc_ram.sv -----
// ----------------------------------------------------------------------------
// vtpc_ram
// Generic simple dual-port RAM with a registered, enabled read.
// ----------------------------------------------------------------------------
module vtpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/virtual_texture_page_cache.sv -----
// ----------------------------------------------------------------------------
// virtual_texture_page_cache
// Page table of a mip-mapped virtual texture with FIFO eviction of stale pages.
// ----------------------------------------------------------------------------
// One item is worked on at a time; the next request is taken once the last
// result of the current one sits in the output register. After reset a
// clearing pass writes every page table entry, during which no request is
// taken. For a page request the page counts of the lower mips are summed one
// mip per cycle through one multiplier, then the page table memory is read and
// written back. A frame tick searches the physical slots for a free one for
// each queued page and pops stale FIFO entries when none is free, then scans
// for stale pages, reading each page table entry through the single read port.
module virtual_texture_page_cache #(
  parameter int MAX_PAGES        = 2048,
  parameter int MAX_SLOTS        = 256,
  parameter int LOAD_QUEUE_DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  vtpc_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output vtpc_pkg::rsp_t rsp,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_index,
  input  logic [15:0]   cfg_data
);
  import vtpc_pkg::*;

  localparam int PW    = $clog2(MAX_PAGES);
  localparam int SW    = MAX_SLOTS > 1 ? $clog2(MAX_SLOTS) : 1;
  localparam int CW    = $clog2(MAX_SLOTS + 1);
  localparam int LQ_IW = LOAD_QUEUE_DEPTH > 1 ? $clog2(LOAD_QUEUE_DEPTH) : 1;
  localparam int LQ_CW = $clog2(LOAD_QUEUE_DEPTH + 1);
  localparam int FW    = $clog2(STALE_DEPTH);

  typedef struct packed {
    logic          loaded;
    logic          stale;
    logic [SW-1:0] slot;
    logic [31:0]   access;
  } pt_rec_t;

  typedef enum logic [14:0] {
    ST_CLR     = 15'b000000000000001,
    ST_IDLE    = 15'b000000000000010,
    ST_REQ_SUM = 15'b000000000000100,
    ST_REQ_ADD = 15'b000000000001000,
    ST_REQ_RD  = 15'b000000000010000,
    ST_T_NEXT  = 15'b000000000100000,
    ST_T_PRD   = 15'b000000001000000,
    ST_T_SLOT  = 15'b000000010000000,
    ST_T_EVH   = 15'b000000100000000,
    ST_T_EVF   = 15'b000001000000000,
    ST_T_EVP   = 15'b000010000000000,
    ST_T_LOAD  = 15'b000100000000000,
    ST_S_RD    = 15'b001000000000000,
    ST_S_CHK   = 15'b010000000000000,
    ST_T_DONE  = 15'b100000000000000
  } state_t;

  state_t state;

  logic [14:0] virtual_width, virtual_height;
  logic [3:0]  page_size_log2, mip_levels;
  logic [4:0]  cache_pages_x, cache_pages_y;
  logic [15:0] stale_age;

  logic [MAX_SLOTS-1:0] slot_used;
  logic [PW-1:0]        lq [LOAD_QUEUE_DEPTH];
  logic [LQ_CW-1:0]     lq_count;
  logic [LQ_CW-1:0]     lq_i;
  logic [FW-1:0]        sf_head;
  logic [FW:0]          sf_count;
  logic [31:0]          last_tick_frame;

  logic [13:0] px_r, py_r;
  logic [3:0]  mip_r, m_r;
  logic [31:0] frame_r;
  logic [34:0] base;
  logic [29:0] prod;
  logic [PW-1:0] idx_r, p_r, v_r, j;
  logic [CW-1:0] s_r;
  logic [SW-1:0] slot_r;
  logic          ev_r;
  logic [PW-1:0] evp_r;
  logic [8:0]    added;

  logic          pt_we, pt_re, sf_we, sf_re;
  logic [PW-1:0] pt_waddr, pt_raddr;
  logic [FW-1:0] sf_waddr, sf_raddr;
  pt_rec_t       pt_wrec, rd;
  logic [$bits(pt_rec_t)-1:0] pt_rdata;
  logic [PW-1:0] sf_rdata;

  logic          out_free, emit;
  rsp_t          emit_data;
  logic [15:0]   cols_m, rows_m, cols_q, rows_q;
  logic [34:0]   gsum;
  logic [31:0]   nslots, ns_raw;
  logic          stale_hit;
  logic          req_oor;

  function automatic logic [15:0] grid_dim(input logic [14:0] texels,
                                           input logic [3:0] mip,
                                           input logic [3:0] sh);
    logic [14:0] w;
    logic [15:0] sum;
    w = texels >> mip;
    if (w == 15'd0) begin
      w = 15'd1;
    end
    sum = 16'(w) + (16'd1 << sh) - 16'd1;
    return sum >> sh;
  endfunction

  assign rd        = pt_rec_t'(pt_rdata);
  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign cols_m    = grid_dim(virtual_width, m_r, page_size_log2);
  assign rows_m    = grid_dim(virtual_height, m_r, page_size_log2);
  assign cols_q    = grid_dim(virtual_width, mip_r, page_size_log2);
  assign rows_q    = grid_dim(virtual_height, mip_r, page_size_log2);
  assign gsum      = base + 35'(prod) + 35'(px_r);
  assign ns_raw    = 32'(cache_pages_x) * 32'(cache_pages_y);
  assign nslots    = ns_raw > 32'(MAX_SLOTS) ? 32'(MAX_SLOTS) : ns_raw;
  assign stale_hit = rd.loaded && !rd.stale && !sf_count[FW] &&
                     ({1'b0, rd.access} + 33'(stale_age) < {1'b0, frame_r});
  assign req_oor   = mip_r >= mip_levels || (m_r == mip_r &&
                     ({2'b00, px_r} >= cols_q || {2'b00, py_r} >= rows_q));

  // Memory ports and the result that the current state hands out.
  always_comb begin
    pt_we     = 1'b0;
    pt_waddr  = j;
    pt_wrec   = '0;
    pt_re     = 1'b0;
    pt_raddr  = j;
    sf_we     = 1'b0;
    sf_waddr  = FW'(sf_head + sf_count[FW-1:0]);
    sf_re     = 1'b0;
    sf_raddr  = sf_head;
    emit      = 1'b0;
    emit_data = '0;
    case (state)
      ST_CLR: begin
        pt_we = 1'b1;
      end
      ST_REQ_SUM: begin
        if (req_oor) begin
          emit = out_free;
          emit_data.kind = KIND_OUT_OF_RANGE;
          emit_data.last = 1'b1;
        end
      end
      ST_REQ_ADD: begin
        if (gsum >= 35'(MAX_PAGES)) begin
          emit = out_free;
          emit_data.kind = KIND_OUT_OF_RANGE;
          emit_data.last = 1'b1;
        end else begin
          pt_re    = 1'b1;
          pt_raddr = gsum[PW-1:0];
        end
      end
      ST_REQ_RD: begin
        emit     = out_free;
        pt_we    = out_free;
        pt_waddr = idx_r;
        pt_wrec  = rd;
        pt_wrec.access = last_tick_frame;
        emit_data.page_index = 11'(idx_r);
        emit_data.last = 1'b1;
        if (rd.loaded) begin
          emit_data.kind = KIND_ALREADY;
          emit_data.slot = 8'(rd.slot);
        end else if (lq_count >= LQ_CW'(LOAD_QUEUE_DEPTH)) begin
          emit_data.kind = KIND_QUEUE_FULL;
        end else begin
          emit_data.kind = KIND_QUEUED;
        end
      end
      ST_T_NEXT: begin
        if (lq_i < lq_count) begin
          pt_re    = 1'b1;
          pt_raddr = lq[lq_i[LQ_IW-1:0]];
        end
      end
      ST_T_PRD: begin
        if (rd.loaded) begin
          emit = out_free;
          emit_data.kind = KIND_SKIPPED;
          emit_data.page_index = 11'(p_r);
          emit_data.slot = 8'(rd.slot);
        end
      end
      ST_T_EVH: begin
        if (sf_count != '0) begin
          sf_re = 1'b1;
        end else begin
          emit = out_free;
          emit_data.kind = KIND_NO_SLOT;
          emit_data.page_index = 11'(p_r);
        end
      end
      ST_T_EVF: begin
        pt_re    = 1'b1;
        pt_raddr = sf_rdata;
      end
      ST_T_EVP: begin
        if (rd.loaded && rd.stale) begin
          pt_we    = 1'b1;
          pt_waddr = v_r;
          pt_wrec  = rd;
          pt_wrec.loaded = 1'b0;
          pt_wrec.stale  = 1'b0;
        end
      end
      ST_T_LOAD: begin
        emit     = out_free;
        pt_we    = out_free;
        pt_waddr = p_r;
        pt_wrec.loaded = 1'b1;
        pt_wrec.slot   = slot_r;
        pt_wrec.access = frame_r;
        emit_data.kind = KIND_LOADED;
        emit_data.page_index = 11'(p_r);
        emit_data.slot = 8'(slot_r);
        emit_data.evicted = ev_r;
        emit_data.evicted_page = 11'(evp_r);
      end
      ST_S_RD: begin
        pt_re = 1'b1;
      end
      ST_S_CHK: begin
        if (stale_hit) begin
          sf_we   = 1'b1;
          pt_we   = 1'b1;
          pt_wrec = rd;
          pt_wrec.stale = 1'b1;
        end
      end
      ST_T_DONE: begin
        emit = out_free;
        emit_data.kind = KIND_TICK_DONE;
        emit_data.stale_added = added;
        emit_data.last = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_CLR;
      j               <= '0;
      rsp_valid       <= 1'b0;
      slot_used       <= '0;
      lq_count        <= '0;
      sf_head         <= '0;
      sf_count        <= '0;
      last_tick_frame <= '0;
      virtual_width   <= 15'd4096;
      virtual_height  <= 15'd4096;
      page_size_log2  <= 4'd7;
      mip_levels      <= 4'd6;
      cache_pages_x   <= 5'd16;
      cache_pages_y   <= 5'd16;
      stale_age       <= 16'd300;
    end else begin
      if (emit) begin
        rsp_valid <= 1'b1;
        rsp       <= emit_data;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_VIRTUAL_WIDTH:  virtual_width  <= cfg_data[14:0];
          CFG_VIRTUAL_HEIGHT: virtual_height <= cfg_data[14:0];
          CFG_PAGE_SIZE_LOG2: page_size_log2 <= cfg_data[3:0];
          CFG_MIP_LEVELS:     mip_levels     <= cfg_data[3:0];
          CFG_CACHE_PAGES_X:  cache_pages_x  <= cfg_data[4:0];
          CFG_CACHE_PAGES_Y:  cache_pages_y  <= cfg_data[4:0];
          CFG_STALE_AGE:      stale_age      <= cfg_data;
          default: begin
          end
        endcase
      end

      case (state)
        ST_CLR: begin
          j <= j + PW'(1);
          if (j == PW'(MAX_PAGES - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (req_valid) begin
            px_r    <= req.page_x;
            py_r    <= req.page_y;
            mip_r   <= req.mip_level;
            frame_r <= req.frame;
            m_r     <= '0;
            base    <= '0;
            if (req.command) begin
              last_tick_frame <= req.frame;
              lq_i  <= '0;
              added <= '0;
              state <= ST_T_NEXT;
            end else begin
              state <= ST_REQ_SUM;
            end
          end
        end
        ST_REQ_SUM: begin
          // An out-of-range request waits here until the output register can take its result.
          if (req_oor) begin
            if (out_free) begin
              state <= ST_IDLE;
            end
          end else if (m_r != mip_r) begin
            base <= base + 35'(cols_m * rows_m);
            m_r  <= m_r + 4'd1;
          end else begin
            prod  <= 30'(py_r * cols_q);
            state <= ST_REQ_ADD;
          end
        end
        ST_REQ_ADD: begin
          idx_r <= gsum[PW-1:0];
          if (emit) begin
            state <= ST_IDLE;
          end else if (pt_re) begin
            state <= ST_REQ_RD;
          end
        end
        ST_REQ_RD: begin
          if (out_free) begin
            if (!rd.loaded && lq_count < LQ_CW'(LOAD_QUEUE_DEPTH)) begin
              lq[lq_count[LQ_IW-1:0]] <= idx_r;
              lq_count <= lq_count + LQ_CW'(1);
            end
            state <= ST_IDLE;
          end
        end
        ST_T_NEXT: begin
          if (lq_i < lq_count) begin
            p_r   <= lq[lq_i[LQ_IW-1:0]];
            state <= ST_T_PRD;
          end else begin
            lq_count <= '0;
            j        <= '0;
            state    <= ST_S_RD;
          end
        end
        ST_T_PRD: begin
          if (rd.loaded) begin
            if (out_free) begin
              lq_i  <= lq_i + LQ_CW'(1);
              state <= ST_T_NEXT;
            end
          end else begin
            ev_r  <= 1'b0;
            evp_r <= '0;
            s_r   <= '0;
            state <= ST_T_SLOT;
          end
        end
        ST_T_SLOT: begin
          // Lowest free slot, one slot per cycle.
          if (32'(s_r) < nslots) begin
            if (!slot_used[s_r[SW-1:0]]) begin
              slot_r <= s_r[SW-1:0];
              state  <= ST_T_LOAD;
            end else begin
              s_r <= s_r + CW'(1);
            end
          end else begin
            state <= ST_T_EVH;
          end
        end
        ST_T_EVH: begin
          if (sf_count != '0) begin
            sf_head  <= sf_head + FW'(1);
            sf_count <= sf_count - (FW + 1)'(1);
            state    <= ST_T_EVF;
          end else if (out_free) begin
            lq_i  <= lq_i + LQ_CW'(1);
            state <= ST_T_NEXT;
          end
        end
        ST_T_EVF: begin
          v_r   <= sf_rdata;
          state <= ST_T_EVP;
        end
        ST_T_EVP: begin
          // Entries whose page was evicted since it was queued are skipped.
          if (rd.loaded && rd.stale) begin
            slot_used[rd.slot] <= 1'b0;
            slot_r <= rd.slot;
            ev_r   <= 1'b1;
            evp_r  <= v_r;
            state  <= ST_T_LOAD;
          end else begin
            state <= ST_T_EVH;
          end
        end
        ST_T_LOAD: begin
          if (out_free) begin
            slot_used[slot_r] <= 1'b1;
            lq_i  <= lq_i + LQ_CW'(1);
            state <= ST_T_NEXT;
          end
        end
        ST_S_RD: begin
          state <= ST_S_CHK;
        end
        ST_S_CHK: begin
          if (stale_hit) begin
            sf_count <= sf_count + (FW + 1)'(1);
            added    <= added + 9'd1;
          end
          if (j == PW'(MAX_PAGES - 1)) begin
            state <= ST_T_DONE;
          end else begin
            j     <= j + PW'(1);
            state <= ST_S_RD;
          end
        end
        ST_T_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  vtpc_ram #(
    .WIDTH($bits(pt_rec_t)),
    .DEPTH(MAX_PAGES)
  ) u_page_table (
    .clk   (clk),
    .we    (pt_we),
    .waddr (pt_waddr),
    .wdata (pt_wrec),
    .re    (pt_re),
    .raddr (pt_raddr),
    .rdata (pt_rdata)
  );

  vtpc_ram #(
    .WIDTH(PW),
    .DEPTH(STALE_DEPTH)
  ) u_stale_fifo (
    .clk   (clk),
    .we    (sf_we),
    .waddr (sf_waddr),
    .wdata (j),
    .re    (sf_re),
    .raddr (sf_raddr),
    .rdata (sf_rdata)
  );

  a_fifo_bound: assert property (@(posedge clk) disable iff (rst)
    sf_count <= (FW + 1)'(STALE_DEPTH))
    else $error("stale FIFO count above its depth");

  a_lq_bound: assert property (@(posedge clk) disable iff (rst)
    lq_count <= LQ_CW'(LOAD_QUEUE_DEPTH))
    else $error("load queue count above its depth");

  a_nonlast_is_load: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.last) |->
      (rsp.kind == KIND_LOADED || rsp.kind == KIND_SKIPPED || rsp.kind == KIND_NO_SLOT))
    else $error("non-final result that is not a tick load result");

  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLR) |-> !rsp_valid)
    else $error("result during the clearing pass");

endmodule

// ----- verif/virtual_texture_page_cache_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// virtual_texture_page_cache_tb
// Self-checking bench for the virtual texture page cache. Requests and frame
// ticks are driven with random gaps, responses are taken under random stall,
// and every response is checked against a behavioral page table model.
// ----------------------------------------------------------------------------
module virtual_texture_page_cache_tb;
  import vtpc_pkg::*;

  localparam int MAX_PAGES  = 2048;
  localparam int MAX_SLOTS  = 256;
  localparam int LQ_DEPTH   = 16;
  localparam int CYCLE_LIMIT = 3000000;
  localparam logic [2:0] CFG_UNUSED_INDEX = 3'd7;

  logic        clk;
  logic        rst;
  logic        req_valid;
  logic        req_stall;
  req_t        req;
  logic        rsp_valid;
  logic        rsp_stall;
  rsp_t        rsp;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  virtual_texture_page_cache DUT (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Model of the page table and its configuration.
  int unsigned vt_width, vt_height, page_log2, mip_count, cache_x, cache_y, age_limit;
  bit          pg_loaded [MAX_PAGES];
  int unsigned pg_slot [MAX_PAGES];
  int unsigned pg_access [MAX_PAGES];
  bit          pg_stale [MAX_PAGES];
  bit          slot_busy [MAX_SLOTS];
  int unsigned load_list [LQ_DEPTH];
  int unsigned load_count;
  int unsigned stale_list [STALE_DEPTH];
  int unsigned stale_head, stale_count;
  int unsigned tick_frame;

  rsp_t        expected_rsp_q [$];
  int          errors;
  int          gaps_on;
  int          stall_on;
  int unsigned frame_now;
  longint      cycles;

  function automatic longint unsigned grid_dim(int unsigned texels, int unsigned mip);
    longint unsigned w;
    w = texels >> mip;
    if (w == 0) w = 1;
    return (w + (64'd1 << page_log2) - 1) >> page_log2;
  endfunction

  function automatic rsp_t make_rsp(logic [2:0] kind, int unsigned pidx, int unsigned slot,
                                    bit ev, int unsigned evp, int unsigned added, bit last);
    rsp_t r;
    r.kind = kind;
    r.page_index = pidx[10:0];
    r.slot = slot[7:0];
    r.evicted = ev;
    r.evicted_page = evp[10:0];
    r.stale_added = added[8:0];
    r.last = last;
    return r;
  endfunction

  function automatic void queue_expected(rsp_t r);
    expected_rsp_q = {expected_rsp_q, r};
  endfunction

  task automatic predict_request(req_t item);
    longint unsigned base, cols, rows, g;
    int unsigned idx;
    base = 0;
    if (item.mip_level >= mip_count) begin
      queue_expected(make_rsp(KIND_OUT_OF_RANGE, 0, 0, 0, 0, 0, 1));
      return;
    end
    for (int m = 0; m < item.mip_level; m++)
      base += grid_dim(vt_width, m) * grid_dim(vt_height, m);
    cols = grid_dim(vt_width, item.mip_level);
    rows = grid_dim(vt_height, item.mip_level);
    g = base + longint'(item.page_y) * cols + item.page_x;
    if (item.page_x >= cols || item.page_y >= rows || g >= MAX_PAGES) begin
      queue_expected(make_rsp(KIND_OUT_OF_RANGE, 0, 0, 0, 0, 0, 1));
      return;
    end
    idx = int'(g);
    pg_access[idx] = tick_frame;
    if (pg_loaded[idx]) begin
      queue_expected(make_rsp(KIND_ALREADY, idx, pg_slot[idx], 0, 0, 0, 1));
    end else if (load_count >= LQ_DEPTH) begin
      queue_expected(make_rsp(KIND_QUEUE_FULL, idx, 0, 0, 0, 0, 1));
    end else begin
      load_list[load_count++] = idx;
      queue_expected(make_rsp(KIND_QUEUED, idx, 0, 0, 0, 0, 1));
    end
  endtask

  task automatic predict_tick(int unsigned frame);
    int unsigned nslots, p, slot, evp, v, added;
    bit ev;
    added = 0;
    nslots = cache_x * cache_y;
    if (nslots > MAX_SLOTS) nslots = MAX_SLOTS;
    tick_frame = frame;
    for (int i = 0; i < load_count; i++) begin
      p = load_list[i];
      slot = MAX_SLOTS;
      ev = 0;
      evp = 0;
      if (pg_loaded[p]) begin
        queue_expected(make_rsp(KIND_SKIPPED, p, pg_slot[p], 0, 0, 0, 0));
        continue;
      end
      for (int s = 0; s < nslots; s++)
        if (!slot_busy[s]) begin
          slot = s;
          break;
        end
      // Dead FIFO entries are popped and skipped until a live one is found.
      while (slot == MAX_SLOTS && stale_count > 0) begin
        v = stale_list[stale_head];
        stale_head = (stale_head + 1) % STALE_DEPTH;
        stale_count--;
        if (pg_loaded[v] && pg_stale[v]) begin
          slot = pg_slot[v];
          pg_loaded[v] = 0;
          pg_stale[v] = 0;
          slot_busy[slot] = 0;
          ev = 1;
          evp = v;
        end
      end
      if (slot == MAX_SLOTS) begin
        queue_expected(make_rsp(KIND_NO_SLOT, p, 0, 0, 0, 0, 0));
        continue;
      end
      pg_loaded[p] = 1;
      pg_slot[p] = slot;
      pg_access[p] = frame;
      slot_busy[slot] = 1;
      queue_expected(make_rsp(KIND_LOADED, p, slot, ev, evp, 0, 0));
    end
    load_count = 0;
    for (int i = 0; i < MAX_PAGES; i++)
      if (pg_loaded[i] && !pg_stale[i] && stale_count < STALE_DEPTH &&
          longint'(pg_access[i]) + longint'(age_limit) < longint'(frame)) begin
        stale_list[(stale_head + stale_count) % STALE_DEPTH] = i;
        stale_count++;
        pg_stale[i] = 1;
        added++;
      end
    queue_expected(make_rsp(KIND_TICK_DONE, 0, 0, 0, 0, added, 1));
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 50) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Enter and leave on a rising edge.
  task automatic send_item(req_t item);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req <= item;
    req_valid <= 1'b1;
    if (item.command) predict_tick(item.frame);
    else predict_request(item);
    do @(posedge clk); while (req_stall);
  endtask

  task automatic send_request(int unsigned x, int unsigned y, int unsigned mip);
    req_t item;
    item = '0;
    item.page_x = x[13:0];
    item.page_y = y[13:0];
    item.mip_level = mip[3:0];
    item.frame = $urandom;
    send_item(item);
  endtask

  task automatic send_tick(int unsigned frame);
    req_t item;
    item.command = 1'b1;
    item.page_x = 14'($urandom);
    item.page_y = 14'($urandom);
    item.mip_level = 4'($urandom);
    item.frame = frame;
    send_item(item);
  endtask

  task automatic wait_idle();
    req_valid <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] index, int unsigned value);
    cfg_index <= index;
    cfg_data <= value[15:0];
    cfg_valid <= 1'b1;
    case (index)
      CFG_VIRTUAL_WIDTH:  vt_width = value & 32'h7FFF;
      CFG_VIRTUAL_HEIGHT: vt_height = value & 32'h7FFF;
      CFG_PAGE_SIZE_LOG2: page_log2 = value & 32'hF;
      CFG_MIP_LEVELS:     mip_count = value & 32'hF;
      CFG_CACHE_PAGES_X:  cache_x = value & 32'h1F;
      CFG_CACHE_PAGES_Y:  cache_y = value & 32'h1F;
      CFG_STALE_AGE:      age_limit = value & 32'hFFFF;
      default: ;
    endcase
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_all(int unsigned w, int unsigned h, int unsigned ps, int unsigned mips,
                           int unsigned cx, int unsigned cy, int unsigned age);
    write_reg(CFG_VIRTUAL_WIDTH, w);
    write_reg(CFG_VIRTUAL_HEIGHT, h);
    write_reg(CFG_PAGE_SIZE_LOG2, ps);
    write_reg(CFG_MIP_LEVELS, mips);
    write_reg(CFG_CACHE_PAGES_X, cx);
    write_reg(CFG_CACHE_PAGES_Y, cy);
    write_reg(CFG_STALE_AGE, age);
  endtask

  task automatic test_request_basics();
    send_request(0, 0, 0);
    send_request(0, 0, 0);
    send_request(31, 31, 0);
    send_request(32, 0, 0);
    send_request(0, 32, 0);
    send_request(16383, 16383, 15);
    send_request(0, 0, 5);
    send_request(0, 0, 6);
    send_tick(10);
    send_request(0, 0, 0);
    send_request(31, 31, 0);
    wait_idle();
  endtask

  task automatic test_queue_full();
    for (int i = 0; i < LQ_DEPTH + 2; i++) send_request(i, 1, 0);
    send_tick(11);
    wait_idle();
  endtask

  task automatic test_eviction();
    write_reg(CFG_CACHE_PAGES_X, 1);
    write_reg(CFG_CACHE_PAGES_Y, 2);
    write_reg(CFG_STALE_AGE, 0);
    send_request(0, 2, 0);
    send_request(1, 2, 0);
    send_request(2, 2, 0);
    send_tick(20);
    send_tick(25);
    // Refreshing one page leaves its FIFO entry in place but still live.
    send_request(0, 2, 0);
    send_request(3, 2, 0);
    send_request(4, 2, 0);
    send_request(5, 2, 0);
    send_tick(26);
    wait_idle();
    write_reg(CFG_CACHE_PAGES_X, 0);
    send_request(6, 2, 0);
    send_request(7, 2, 0);
    send_tick(32'hFFFF_FFFF);
    send_request(8, 2, 0);
    send_tick(0);
    wait_idle();
  endtask

  task automatic test_config_extremes();
    write_all(16384, 1, 0, 15, 16, 16, 65535);
    write_reg(CFG_UNUSED_INDEX, 16'hFFFF);
    send_request(2047, 0, 0);
    send_request(2048, 0, 0);
    send_request(0, 0, 1);
    send_request(0, 1, 0);
    send_tick(70000);
    wait_idle();
    write_all(1, 1, 10, 1, 31, 31, 0);
    send_request(0, 0, 0);
    send_request(1, 0, 0);
    send_request(0, 0, 1);
    send_tick(5);
    send_tick(7);
    wait_idle();
    write_all(32767, 32767, 15, 0, 1, 1, 1);
    send_request(0, 0, 0);
    wait_idle();
  endtask

  task automatic send_random_item();
    req_t item;
    int r, mip, lim;
    longint unsigned cols, rows;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      if ($urandom_range(0, 9) == 0) frame_now = $urandom;
      else frame_now += $urandom_range(0, 60);
      send_tick(frame_now);
    end else if (r < 22 || mip_count == 0) begin
      item = '0;
      item.command = 1'b0;
      item.page_x = 14'($urandom);
      item.page_y = 14'($urandom);
      item.mip_level = 4'($urandom);
      item.frame = $urandom;
      send_item(item);
    end else begin
      mip = $urandom_range(0, mip_count - 1);
      cols = grid_dim(vt_width, mip);
      rows = grid_dim(vt_height, mip);
      lim = cols > 6 ? 6 : int'(cols);
      cols = $urandom_range(0, lim - 1);
      lim = rows > 4 ? 4 : int'(rows);
      rows = $urandom_range(0, lim - 1);
      send_request(int'(cols), int'(rows), mip);
    end
  endtask

  task automatic test_random();
    for (int phase = 0; phase < 4; phase++) begin
      if (phase == 3)
        write_all(4096, 4096, 7, 6, 16, 16, 300);
      else
        write_all($urandom_range(1, 2048), $urandom_range(1, 2048), $urandom_range(3, 8),
                  $urandom_range(1, 8), $urandom_range(1, 3), $urandom_range(1, 3),
                  $urandom_range(0, 40));
      gaps_on = phase != 1;
      stall_on = phase != 1;
      for (int i = 0; i < 12; i++) send_random_item();
      wait_idle();
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  int stall_left;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (stall_on && $urandom_range(0, 99) < 30) begin
      stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(1, 3);
    end
    rsp_stall <= (stall_left > 1) || (stall_left == 0 && stall_on && $urandom_range(0, 3) == 0);
  end

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_rsp_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected response, expected none, actual %h", $time, rsp);
      end else begin
        want = expected_rsp_q.pop_front();
        check_field("kind", want.kind, rsp.kind);
        check_field("page_index", want.page_index, rsp.page_index);
        check_field("slot", want.slot, rsp.slot);
        check_field("evicted", want.evicted, rsp.evicted);
        check_field("evicted_page", want.evicted_page, rsp.evicted_page);
        check_field("stale_added", want.stale_added, rsp.stale_added);
        check_field("last", want.last, rsp.last);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    rsp_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cycles = 0;
    errors = 0;
    stall_left = 0;
    gaps_on = 1;
    stall_on = 1;
    frame_now = 100;
    vt_width = 4096; vt_height = 4096; page_log2 = 7; mip_count = 6;
    cache_x = 16; cache_y = 16; age_limit = 300;
    load_count = 0; stale_head = 0; stale_count = 0; tick_frame = 0;
    foreach (pg_loaded[i]) begin
      pg_loaded[i] = 0;
      pg_slot[i] = 0;
      pg_access[i] = 0;
      pg_stale[i] = 0;
    end
    foreach (slot_busy[i]) slot_busy[i] = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_request_basics();
    test_queue_full();
    test_eviction();
    test_config_extremes();
    test_random();
    wait_idle();
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
